// File: hdl/mkkt_pkg.sv
// ----------------------------------------------------------------------------
// mkkt_pkg
// Shared constants, types and helpers of the matrix keypad key tracker.
// ----------------------------------------------------------------------------
package mkkt_pkg;

	localparam int ROW_COUNT  = 4;
	localparam int COL_COUNT  = 4;
	localparam int LIST_SLOTS = 10;

	localparam int KEY_COUNT = ROW_COUNT * COL_COUNT;
	// positions of 16 and up have no input bit and never change anything
	localparam int WALK_KEYS = (KEY_COUNT < 16) ? KEY_COUNT : 16;
	localparam int KEY_W     = (WALK_KEYS > 1) ? $clog2(WALK_KEYS) : 1;
	localparam int SLOT_W    = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;

	localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(WALK_KEYS - 1);

	localparam int CFG_W       = 16;
	localparam int CFG_INDEX_W = 1;
	localparam int TIME_W      = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_SCAN_INTERVAL = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD          = 1'b1;

	localparam logic [CFG_W-1:0] SCAN_INTERVAL_RESET = 16'd10;
	localparam logic [CFG_W-1:0] HOLD_RESET          = 16'd500;

	localparam logic [1:0] KEY_IDLE     = 2'd0;
	localparam logic [1:0] KEY_PRESSED  = 2'd1;
	localparam logic [1:0] KEY_HOLD     = 2'd2;
	localparam logic [1:0] KEY_RELEASED = 2'd3;

	typedef struct packed {
		logic             tick;
		logic             mark_scan;
		logic             free_slots;
		logic             walk;
		logic [KEY_W-1:0] key;
		logic             emit;
	} mkkt_cmd_t;

	typedef struct packed {
		logic scan_due;
		logic events_left;
		logic out_room;
	} mkkt_sts_t;

	// lowest set bit of a slot mask
	function automatic logic [SLOT_W-1:0] first_set(input logic [LIST_SLOTS-1:0] v);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int i = LIST_SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = SLOT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: hdl/matrix_keypad_key_tracker_core.sv
// ----------------------------------------------------------------------------
// matrix_keypad_key_tracker_core
// Multi-key keypad tracker: per-slot idle/pressed/hold/released machines
// driven by millisecond ticks that carry the sampled key matrix.
// ----------------------------------------------------------------------------
// Each input transaction is one millisecond tick. A tick with no scan due
// passes through S_CHECK and back to S_IDLE. A tick that runs a scan goes
// through S_CHECK, S_FREE, S_WALK and S_EMIT: S_WALK walks the key positions
// (rows * columns, at most 16; one key per cycle through a single slot search
// unit) and S_EMIT drains the change events, each leaving through the output
// register at most once per cycle while the output has room; with ten slots
// there are at most ten events per scan. A new tick is taken once the
// events of the previous scan are all in or past the output register.
// ----------------------------------------------------------------------------
module matrix_keypad_key_tracker_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mkkt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mkkt_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,  // pressed_keys[15:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,  // slot[3:0], key_code[7:4], new_state[9:8]
	output logic                             m_tlast   // last_event
);
	import mkkt_pkg::*;

	mkkt_cmd_t cmd;
	mkkt_sts_t sts;

	mkkt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mkkt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pressed_keys (s_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast)
	);

endmodule

// File: hdl/mkkt_ctrl.sv
// ----------------------------------------------------------------------------
// mkkt_ctrl
// Sequencer: takes a tick, checks the scan interval, frees idle slots,
// walks the keys one per cycle and drains the change events.
// ----------------------------------------------------------------------------
module mkkt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  mkkt_pkg::mkkt_sts_t sts,
	output mkkt_pkg::mkkt_cmd_t cmd
);
	import mkkt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_FREE  = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [KEY_W-1:0] key_q;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.key        = key_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.tick = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.scan_due) begin
					cmd.mark_scan = 1'b1;
					state_d       = S_FREE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_FREE: begin
				cmd.free_slots = 1'b1;
				state_d        = S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (key_q == LAST_KEY) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!sts.events_left) begin
					state_d = S_IDLE;
				end else if (sts.out_room) begin
					cmd.emit = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			key_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FREE) begin
				key_q <= '0;
			end else if (state_q == S_WALK && key_q != LAST_KEY) begin
				key_q <= key_q + 1'b1;
			end
		end
	end

endmodule

// File: hdl/mkkt_dpath.sv
// ----------------------------------------------------------------------------
// mkkt_dpath
// Timers, configuration registers, key list slots and the event output
// register of the key tracker.
// ----------------------------------------------------------------------------
module mkkt_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mkkt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mkkt_pkg::CFG_W-1:0]     cfg_data,
	input  logic [15:0]                    pressed_keys,
	input  mkkt_pkg::mkkt_cmd_t            cmd,
	output mkkt_pkg::mkkt_sts_t            sts,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,
	output logic                           m_tlast
);
	import mkkt_pkg::*;

	logic [CFG_W-1:0]  interval_q;
	logic [CFG_W-1:0]  hold_ms_q;
	logic [TIME_W-1:0] ms_q;
	logic [TIME_W-1:0] last_scan_q;
	logic [TIME_W-1:0] hold_start_q;
	logic [15:0]       keys_q;

	logic [LIST_SLOTS-1:0] used_q;
	logic [LIST_SLOTS-1:0] changed_q;
	logic [3:0]            code_q  [LIST_SLOTS];
	logic [1:0]            kstate_q[LIST_SLOTS];

	logic       out_valid_q;
	logic [3:0] out_slot_q;
	logic [3:0] out_code_q;
	logic [1:0] out_state_q;
	logic       out_last_q;

	logic [3:0]            code4;
	logic                  closed;
	logic [LIST_SLOTS-1:0] hit;
	logic                  found;
	logic                  any_free;
	logic [SLOT_W-1:0]     hit_idx;
	logic [SLOT_W-1:0]     free_idx;
	logic [SLOT_W-1:0]     tgt_idx;
	logic                  act;
	logic [SLOT_W-1:0]     ev_idx;
	logic [SLOT_W-1:0]     rd_idx;
	logic [1:0]            rd_state;
	logic [1:0]            cur_state;
	logic [1:0]            nxt_state;
	logic                  chg;
	logic                  restart;
	logic                  held;
	logic [LIST_SLOTS-1:0] ev_rest;

	assign code4  = 4'(cmd.key);
	assign closed = keys_q[code4];

	always_comb begin
		for (int s = 0; s < LIST_SLOTS; s++) begin
			hit[s] = used_q[s] && (code_q[s] == code4);
		end
	end

	assign found    = |hit;
	assign any_free = ~&used_q;
	assign hit_idx  = first_set(hit);
	assign free_idx = first_set(~used_q);
	assign tgt_idx  = found ? hit_idx : free_idx;
	assign act      = found || (closed && any_free);

	assign ev_idx   = first_set(changed_q);
	assign rd_idx   = cmd.emit ? ev_idx : tgt_idx;
	assign rd_state = kstate_q[rd_idx];
	assign ev_rest  = changed_q & ~(LIST_SLOTS'(1) << ev_idx);

	assign cur_state = found ? rd_state : KEY_IDLE;
	assign held      = (ms_q - hold_start_q) > {{(TIME_W - CFG_W){1'b0}}, hold_ms_q};

	always_comb begin
		nxt_state = cur_state;
		chg       = 1'b0;
		restart   = 1'b0;
		case (cur_state)
			KEY_IDLE: begin
				if (closed) begin
					nxt_state = KEY_PRESSED;
					chg       = 1'b1;
					restart   = 1'b1;
				end
			end
			KEY_PRESSED: begin
				if (held) begin
					nxt_state = KEY_HOLD;
					chg       = 1'b1;
				end else if (!closed) begin
					nxt_state = KEY_RELEASED;
					chg       = 1'b1;
				end
			end
			KEY_HOLD: begin
				if (!closed) begin
					nxt_state = KEY_RELEASED;
					chg       = 1'b1;
				end
			end
			default: begin
				nxt_state = KEY_IDLE;
				chg       = 1'b1;
			end
		endcase
	end

	assign sts.scan_due    = (ms_q - last_scan_q) > {{(TIME_W - CFG_W){1'b0}}, interval_q};
	assign sts.events_left = |changed_q;
	assign sts.out_room    = !out_valid_q || m_tready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= SCAN_INTERVAL_RESET;
			hold_ms_q  <= HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCAN_INTERVAL: interval_q <= (cfg_data == '0) ? CFG_W'(1) : cfg_data;
				REG_HOLD:          hold_ms_q  <= cfg_data;
				default:           ;
			endcase
		end
	end

	// timers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q         <= '0;
			last_scan_q  <= '0;
			hold_start_q <= '0;
		end else begin
			if (cmd.tick) begin
				ms_q <= ms_q + 1'b1;
			end
			if (cmd.mark_scan) begin
				last_scan_q <= ms_q;
			end
			if (cmd.walk && act && restart) begin
				hold_start_q <= ms_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			keys_q <= pressed_keys;
		end
	end

	// key list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			changed_q <= '0;
			for (int s = 0; s < LIST_SLOTS; s++) begin
				code_q[s]   <= '0;
				kstate_q[s] <= KEY_IDLE;
			end
		end else begin
			if (cmd.free_slots) begin
				for (int s = 0; s < LIST_SLOTS; s++) begin
					if (kstate_q[s] == KEY_IDLE) begin
						used_q[s]    <= 1'b0;
						changed_q[s] <= 1'b0;
					end
				end
			end
			if (cmd.walk && act) begin
				used_q[tgt_idx]    <= 1'b1;
				code_q[tgt_idx]    <= code4;
				kstate_q[tgt_idx]  <= nxt_state;
				changed_q[tgt_idx] <= chg;
			end
			if (cmd.emit) begin
				changed_q[ev_idx] <= 1'b0;
			end
		end
	end

	// event output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_slot_q  <= 4'(ev_idx);
			out_code_q  <= code_q[ev_idx];
			out_state_q <= rd_state;
			out_last_q  <= (ev_rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_state_q, out_code_q, out_slot_q};
	assign m_tlast  = out_last_q;

endmodule

// File: bench/matrix_keypad_key_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// matrix_keypad_key_tracker_core_tb
// Drives millisecond ticks carrying key matrix samples into the tracker and
// checks every change event against a cycle-free model of the slot list, the
// per-key state machines and the shared hold timer, across several scan and
// hold settings and with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module matrix_keypad_key_tracker_core_tb;
	import mkkt_pkg::*;

	localparam int LIMIT_TIME    = 12_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_CYCLES  = 20000;
	localparam int RANDOM_TICKS  = 143;

	typedef struct packed {
		logic [3:0] slot;
		logic [3:0] key_code;
		logic [1:0] new_state;
		logic       last_event;
	} key_event_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [15:0]            s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [15:0]            m_tdata;
	logic                   m_tlast;

	// model of the tracker
	logic [31:0] ms_now;
	logic [31:0] last_scan;
	logic [31:0] hold_start;
	logic [15:0] scan_iv;
	logic [15:0] hold_lim;
	bit          slot_used [LIST_SLOTS];
	logic [3:0]  slot_code [LIST_SLOTS];
	logic [1:0]  slot_state [LIST_SLOTS];
	bit          slot_changed [LIST_SLOTS];

	key_event_t pending_events[$];
	key_event_t seen_event;
	key_event_t want_event;
	int         errors        = 0;
	int         src_idle_pct  = 0;
	int         sink_idle_pct = 0;

	matrix_keypad_key_tracker_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	function automatic void tracker_reset();
		ms_now     = '0;
		last_scan  = '0;
		hold_start = '0;
		scan_iv    = SCAN_INTERVAL_RESET;
		hold_lim   = HOLD_RESET;
		for (int s = 0; s < LIST_SLOTS; s++) begin
			slot_used[s]    = 1'b0;
			slot_code[s]    = '0;
			slot_state[s]   = KEY_IDLE;
			slot_changed[s] = 1'b0;
		end
	endfunction

	function automatic void reg_apply(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
		if (idx == REG_SCAN_INTERVAL) begin
			scan_iv = (val == 16'd0) ? 16'd1 : val;
		end else if (idx == REG_HOLD) begin
			hold_lim = val;
		end
	endfunction

	function automatic void move_slot(int s, logic [1:0] st);
		slot_state[s]   = st;
		slot_changed[s] = 1'b1;
	endfunction

	function automatic void slot_advance(int s, bit closed);
		logic [31:0] held_for;
		held_for = ms_now - hold_start;
		slot_changed[s] = 1'b0;
		case (slot_state[s])
			KEY_IDLE: begin
				if (closed) begin
					move_slot(s, KEY_PRESSED);
					hold_start = ms_now;
				end
			end
			KEY_PRESSED: begin
				// hold wins over release
				if (held_for > {16'd0, hold_lim}) begin
					move_slot(s, KEY_HOLD);
				end else if (!closed) begin
					move_slot(s, KEY_RELEASED);
				end
			end
			KEY_HOLD: begin
				if (!closed) begin
					move_slot(s, KEY_RELEASED);
				end
			end
			default: begin
				move_slot(s, KEY_IDLE);
			end
		endcase
	endfunction

	function automatic void run_scan(logic [15:0] keys);
		int  code;
		bit  closed;
		bit  found;
		for (int s = 0; s < LIST_SLOTS; s++) begin
			if (slot_state[s] == KEY_IDLE) begin
				slot_used[s]    = 1'b0;
				slot_changed[s] = 1'b0;
			end
		end
		for (int r = 0; r < ROW_COUNT; r++) begin
			for (int c = 0; c < COL_COUNT; c++) begin
				code   = r * COL_COUNT + c;
				closed = (code < 16) ? keys[code] : 1'b0;
				found  = 1'b0;
				for (int s = 0; s < LIST_SLOTS; s++) begin
					if (slot_used[s] && slot_code[s] == code) begin
						found = 1'b1;
						slot_advance(s, closed);
						break;
					end
				end
				if (!found && closed) begin
					for (int s = 0; s < LIST_SLOTS; s++) begin
						if (!slot_used[s]) begin
							slot_used[s]  = 1'b1;
							slot_code[s]  = code[3:0];
							slot_state[s] = KEY_IDLE;
							slot_advance(s, 1'b1);
							break;
						end
					end
				end
			end
		end
	endfunction

	function automatic void tracker_tick(logic [15:0] keys);
		logic [31:0] since;
		key_event_t  ev;
		int          remaining;
		ms_now = ms_now + 32'd1;
		since  = ms_now - last_scan;
		if (since <= {16'd0, scan_iv}) begin
			return;
		end
		run_scan(keys);
		last_scan = ms_now;
		remaining = 0;
		for (int s = 0; s < LIST_SLOTS; s++) begin
			if (slot_changed[s]) begin
				remaining++;
			end
		end
		for (int s = 0; s < LIST_SLOTS; s++) begin
			if (slot_changed[s]) begin
				remaining--;
				ev.slot       = 4'(s);
				ev.key_code   = slot_code[s];
				ev.new_state  = slot_state[s];
				ev.last_event = (remaining == 0);
				pending_events.push_back(ev);
			end
		end
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_event = {m_tdata[3:0], m_tdata[7:4], m_tdata[9:8], m_tlast};
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event expected none actual slot %0d key %0d state %0d last %0b",
					$time, seen_event.slot, seen_event.key_code, seen_event.new_state,
					seen_event.last_event);
				errors++;
			end else begin
				want_event = pending_events.pop_front();
				check_field("slot", want_event.slot, seen_event.slot);
				check_field("key_code", want_event.key_code, seen_event.key_code);
				check_field("new_state", want_event.new_state, seen_event.new_state);
				check_field("last_event", want_event.last_event, seen_event.last_event);
			end
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_apply(idx, val);
	endtask

	task automatic send_tick(logic [15:0] keys);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= keys;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		tracker_tick(keys);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// default interval: the first scan fills the list, six keys find no slot
	task automatic test_reset_scan();
		repeat (11) send_tick(16'hFFFF);
	endtask

	// zero interval stores one, zero hold sends every pressed key to hold,
	// open keys too; keys left out earlier get slots once the list frees up
	task automatic test_hold_corners();
		logic [15:0] pattern [12] = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'hFC00, 16'hFC00, 16'h0000, 16'h0000,
			16'h0000, 16'h0000};
		wait_idle();
		write_reg(REG_SCAN_INTERVAL, 16'd0);
		write_reg(REG_HOLD, 16'd0);
		foreach (pattern[i]) begin
			send_tick(pattern[i]);
		end
	endtask

	task automatic test_release_before_hold();
		logic [15:0] pattern [6] = '{16'h0001, 16'h0001, 16'h0000, 16'h0000,
			16'h0000, 16'h0000};
		wait_idle();
		write_reg(REG_HOLD, 16'hFFFF);
		foreach (pattern[i]) begin
			send_tick(pattern[i]);
		end
	endtask

	task automatic test_slow_interval();
		wait_idle();
		write_reg(REG_SCAN_INTERVAL, 16'hFFFF);
		repeat (3) send_tick(16'($urandom()));
	endtask

	// mostly held key sets that change a key at a time, some noise ticks
	task automatic test_random_traffic(int src_pct, int sink_pct, logic [15:0] iv,
		logic [15:0] hold);
		logic [15:0] held;
		int          pick;
		wait_idle();
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		write_reg(REG_SCAN_INTERVAL, iv);
		write_reg(REG_HOLD, hold);
		held = '0;
		repeat (RANDOM_TICKS) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_tick(16'($urandom()));
			end else begin
				if (pick < 30) begin
					held = held ^ (16'd1 << $urandom_range(0, 15));
				end else if (pick < 34) begin
					held = '0;
				end else if (pick < 37) begin
					held = 16'($urandom());
				end
				send_tick(held);
			end
		end
	endtask

	initial begin
		int waited;
		tracker_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_scan();
		test_hold_corners();
		test_release_before_hold();
		test_slow_interval();
		test_random_traffic(32, 80, 16'd1, 16'($urandom_range(0, 12)));
		test_random_traffic(80, 32, 16'($urandom_range(1, 3)), 16'($urandom_range(0, 30)));
		test_random_traffic(0, 0, 16'd2, 16'($urandom_range(4, 60)));
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_events.size() != 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (pending_events.size() != 0) begin
			$display("%0t: %0d events expected but never seen", $time, pending_events.size());
			errors++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#(LIMIT_TIME);
		$display("simulation failed");
		$finish;
	end

endmodule

// File: matrix_keypad_key_tracker_core.f
hdl/mkkt_pkg.sv
hdl/mkkt_ctrl.sv
hdl/mkkt_dpath.sv
hdl/matrix_keypad_key_tracker_core.sv
bench/matrix_keypad_key_tracker_core_tb.sv
